### design/hbbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the hashed block buffer cache.
// Used by hbbc_ctrl, hbbc_dp and hashed_block_buffer_cache.
package hbbc_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int NUM_BUCKETS_DEF = 13;
  localparam int BKT_W   = 4;
  localparam int REF_W   = 8;
  localparam int TIME_W  = 32;
  localparam int DEV_W   = 16;
  localparam int BLK_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int STAT_W  = 3;
  localparam int HASH_STEPS = 2;
  localparam int HCNT_W  = $clog2(HASH_STEPS);

  typedef enum logic [1:0] {
    FUNC_GET     = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PIN     = 2'd2,
    FUNC_UNPIN   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_HOME  = 3'd1,
    ST_OTHER = 3'd2,
    ST_NONE  = 3'd3,
    ST_ERR   = 3'd4
  } stat_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [DEV_W-1:0]  device_id;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] buffer_slot;
    logic [TIME_W-1:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [STAT_W-1:0] status;
    logic              needs_fill;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic hash_last;
    logic scan_last;
    logic out_busy;
  } stat_bus_t;

endpackage

### design/hbbc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the buffer cache: load, hash and scan (get only), commit.
// Depends on hbbc_pkg.
module hbbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbbc_pkg::stat_bus_t st,
  output hbbc_pkg::cmd_t     cmd
);
  import hbbc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // is_get looks at the incoming item during load
          state_next = st.is_get ? S_HASH : S_FINISH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/hbbc_dp.sv
`timescale 1ns / 1ps
// Datapath: tag store, hash remainder unit, bucket scan and commit logic.
// Depends on hbbc_pkg.
module hbbc_dp #(
  parameter int NUM_BUFFERS = hbbc_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = hbbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hbbc_pkg::req_t      in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hbbc_pkg::rsp_t      out_data,
  input  hbbc_pkg::cmd_t      cmd,
  output hbbc_pkg::stat_bus_t st
);
  import hbbc_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam logic [BKT_W:0] NB = (BKT_W+1)'(NUM_BUCKETS);
  // 256^k mod bucket count, weight of byte k of the block number
  localparam int PW0 = 1 % NUM_BUCKETS;
  localparam int PW1 = 256 % NUM_BUCKETS;
  localparam int PW2 = (PW1 * 256) % NUM_BUCKETS;
  localparam int PW3 = (PW2 * 256) % NUM_BUCKETS;

  // tag store
  logic [DEV_W-1:0]  tag_device        [NUM_BUFFERS];
  logic [BLK_W-1:0]  tag_block         [NUM_BUFFERS];
  logic [REF_W-1:0]  ref_count         [NUM_BUFFERS];
  logic              contents_valid    [NUM_BUFFERS];
  logic [TIME_W-1:0] last_release_time [NUM_BUFFERS];
  logic [BKT_W-1:0]  bucket_of_slot    [NUM_BUFFERS];

  req_t              req;
  logic [BKT_W+1:0]  hash_part;
  logic [BKT_W-1:0]  hash_rem;
  logic [HCNT_W-1:0] hash_cnt;
  logic [IDX_W-1:0]  scan_idx;
  logic              hit_found, cand_found;
  logic [IDX_W-1:0]  hit_idx, cand_idx;
  logic [BKT_W-1:0]  cand_dist;
  logic [TIME_W-1:0] cand_time;

  // constant table: (byte value * weight) mod bucket count
  function automatic logic [BKT_W-1:0] byte_rem(input logic [7:0] b, input int pw);
    logic [BKT_W-1:0] r;
    r = '0;
    for (int v = 0; v < 256; v++)
      if (b == 8'(v)) r = BKT_W'((v * pw) % NUM_BUCKETS);
    return r;
  endfunction

  // constant table: final fold of the summed byte remainders
  function automatic logic [BKT_W-1:0] fold_rem(input logic [BKT_W+1:0] s);
    logic [BKT_W-1:0] r;
    r = '0;
    for (int v = 0; v < 2**(BKT_W+2); v++)
      if (s == (BKT_W+2)'(v)) r = BKT_W'(v % NUM_BUCKETS);
    return r;
  endfunction

  assign st.is_get    = (func_t'(in_data.func) == FUNC_GET);
  assign st.hash_last = (hash_cnt == HCNT_W'(HASH_STEPS - 1));
  assign st.scan_last = (scan_idx == IDX_W'(NUM_BUFFERS - 1));
  assign st.out_busy  = out_valid && out_stall;

  // read port
  logic [IDX_W-1:0]  slot_idx, commit_idx, rd_idx;
  logic              slot_ok, req_get;
  logic [DEV_W-1:0]  r_dev;
  logic [BLK_W-1:0]  r_blk;
  logic [REF_W-1:0]  r_ref;
  logic              r_valid;
  logic [TIME_W-1:0] r_time;
  logic [BKT_W-1:0]  r_bkt;
  logic [BKT_W:0]    bkt_gap_w;
  logic [BKT_W-1:0]  bkt_gap;
  logic              match, better;

  assign req_get    = (func_t'(req.func) == FUNC_GET);
  assign slot_idx   = IDX_W'(req.buffer_slot);
  assign slot_ok    = (32'(req.buffer_slot) < NUM_BUFFERS);
  assign commit_idx = req_get ? (hit_found ? hit_idx : cand_idx) : slot_idx;
  assign rd_idx     = cmd.scan_step ? scan_idx : commit_idx;

  always_comb begin
    r_dev   = tag_device[rd_idx];
    r_blk   = tag_block[rd_idx];
    r_ref   = ref_count[rd_idx];
    r_valid = contents_valid[rd_idx];
    r_time  = last_release_time[rd_idx];
    r_bkt   = bucket_of_slot[rd_idx];
    // forward distance from home bucket, home itself is 0
    if (r_bkt >= hash_rem) bkt_gap_w = {1'b0, r_bkt} - {1'b0, hash_rem};
    else                   bkt_gap_w = {1'b0, r_bkt} + NB - {1'b0, hash_rem};
    bkt_gap = bkt_gap_w[BKT_W-1:0];
    match = (r_bkt == hash_rem) && (r_dev == req.device_id) &&
            (r_blk == req.block_number);
    better = (r_ref == '0) &&
             (!cand_found || bkt_gap < cand_dist ||
              (bkt_gap == cand_dist && r_time < cand_time));
  end

  // commit decode
  logic              we_tag, we_ref, we_valid, we_time, we_bkt;
  logic [REF_W-1:0]  w_ref;
  rsp_t              rsp;

  always_comb begin
    we_tag = 1'b0; we_ref = 1'b0; we_valid = 1'b0; we_time = 1'b0; we_bkt = 1'b0;
    w_ref  = r_ref;
    rsp.slot_out   = req.buffer_slot;
    rsp.status     = ST_OK;
    rsp.needs_fill = 1'b0;
    if (req_get) begin
      rsp.slot_out = SLOT_W'(commit_idx);
      if (hit_found) begin
        we_ref   = 1'b1;
        w_ref    = (r_ref == '1) ? r_ref : r_ref + 1'b1;
        we_valid = 1'b1;
        rsp.needs_fill = !r_valid;
      end else if (cand_found) begin
        we_tag = 1'b1; we_ref = 1'b1; we_valid = 1'b1; we_bkt = 1'b1;
        w_ref  = REF_W'(1);
        rsp.status     = (cand_dist == '0) ? ST_HOME : ST_OTHER;
        rsp.needs_fill = 1'b1;
      end else begin
        rsp.slot_out = '0;
        rsp.status   = ST_NONE;
      end
    end else if (!slot_ok) begin
      rsp.status = ST_ERR;
    end else if (func_t'(req.func) == FUNC_PIN) begin
      we_ref = 1'b1;
      w_ref  = (r_ref == '1) ? r_ref : r_ref + 1'b1;
    end else if (r_ref == '0) begin
      rsp.status = ST_ERR;
    end else begin
      we_ref  = 1'b1;
      w_ref   = r_ref - 1'b1;
      we_time = (func_t'(req.func) == FUNC_RELEASE) && (w_ref == '0);
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      cand_found <= 1'b0;
      hash_cnt   <= '0;
      scan_idx   <= '0;
      hash_rem   <= '0;
    end else if (cmd.load) begin
      req        <= in_data;
      hash_rem   <= '0;
      hash_cnt   <= '0;
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      cand_found <= 1'b0;
    end else if (cmd.hash_step) begin
      // first step sums the byte remainders, second folds the sum
      if (hash_cnt == '0) begin
        hash_part <= (BKT_W+2)'(byte_rem(req.block_number[7:0],   PW0)) +
                     (BKT_W+2)'(byte_rem(req.block_number[15:8],  PW1)) +
                     (BKT_W+2)'(byte_rem(req.block_number[23:16], PW2)) +
                     (BKT_W+2)'(byte_rem(req.block_number[31:24], PW3));
      end else begin
        hash_rem <= fold_rem(hash_part);
      end
      hash_cnt <= hash_cnt + 1'b1;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
      end
      if (better) begin
        cand_found <= 1'b1;
        cand_idx   <= scan_idx;
        cand_dist  <= bkt_gap;
        cand_time  <= r_time;
      end
    end
  end

  // store updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_device[i]        <= '0;
        tag_block[i]         <= '0;
        ref_count[i]         <= '0;
        contents_valid[i]    <= 1'b0;
        last_release_time[i] <= '0;
        bucket_of_slot[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (we_tag) begin
        tag_device[commit_idx] <= req.device_id;
        tag_block[commit_idx]  <= req.block_number;
      end
      if (we_ref)   ref_count[commit_idx]         <= w_ref;
      if (we_valid) contents_valid[commit_idx]    <= 1'b1;
      if (we_time)  last_release_time[commit_idx] <= req.now_ticks;
      if (we_bkt)   bucket_of_slot[commit_idx]    <= hash_rem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= rsp;
  end

endmodule

### design/hashed_block_buffer_cache.sv
`timescale 1ns / 1ps
// Hashed block buffer cache tag manager, top level.
// Release, pin, unpin: load, then commit of the result. Get: hash (byte
// remainder tables summed, then folded), a scan over all NUM_BUFFERS slots,
// then commit; one item at a time, and a stalled result holds off the next
// item. Synchronous reset clears all tags, counts, valid bits, times and
// buckets.
module hashed_block_buffer_cache #(
  parameter int NUM_BUFFERS = hbbc_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = hbbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hbbc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hbbc_pkg::rsp_t out_data
);
  import hbbc_pkg::*;

  cmd_t      cmd;
  stat_bus_t st;

  // sequencer: idle -> (hash -> scan) -> finish
  hbbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // store, remainder unit, single pass scan that ranks free buffers by
  // (bucket distance from home, release time, index) and finds the hit
  hbbc_dp #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
